/* sv/ozq_pkg.sv */
// ----------------------------------------------------------------------------
// ozq_pkg: shared types and constants for the obstacle zone qualifier
// Holds the transaction payload types, the register index codes and the
// fixed widths and constants used by the zone lanes and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ozq_pkg;

	localparam int MM_W    = 16;
	localparam int CM_W    = 13;
	localparam int RUN_W   = 4;
	localparam int QUAL_W  = 4;
	localparam int ZONES   = 3;

	localparam logic [RUN_W-1:0] RUN_MAX = '1;
	localparam logic [CM_W-1:0]  CM_MAX  = '1;

	// Reciprocal of ten scaled by 2^19; exact truncating division for 16-bit values.
	localparam logic [MM_W-1:0] DIV10_RECIP = 16'd52429;
	localparam int              DIV10_SHIFT = 19;

	localparam logic [CM_W-1:0]   STOP_THR_RST  = 13'd10;
	localparam logic [CM_W-1:0]   SLOW_THR_RST  = 13'd30;
	localparam logic [CM_W-1:0]   SAFE_DIST_RST = 13'd50;
	localparam logic [QUAL_W-1:0] QUALIFY_RST   = 4'd2;

	typedef enum logic [1:0] {
		REG_STOP_THR  = 2'd0,
		REG_SLOW_THR  = 2'd1,
		REG_SAFE_DIST = 2'd2,
		REG_QUALIFY   = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic            reading_valid;
		logic [MM_W-1:0] center_mm;
		logic [MM_W-1:0] left_mm;
		logic [MM_W-1:0] right_mm;
	} in_item_t;

	typedef struct packed {
		logic            stop_alert;
		logic            slow_alert;
		logic [CM_W-1:0] front_cm;
		logic [CM_W-1:0] left_cm;
		logic [CM_W-1:0] right_cm;
	} out_item_t;

	typedef struct packed {
		logic [CM_W-1:0]   stop_thr;
		logic [CM_W-1:0]   slow_thr;
		logic [QUAL_W-1:0] qualify;
	} zone_cfg_t;

	typedef struct packed {
		logic stop;
		logic slow;
	} lane_flags_t;

endpackage

`default_nettype wire

/* sv/ozq_cm_conv.sv */
// ----------------------------------------------------------------------------
// ozq_cm_conv: millimetre to centimetre conversion stage
// Divides a 16-bit distance by ten through a reciprocal multiplication and
// registers the truncated centimetre value.
// ----------------------------------------------------------------------------
`default_nettype none

module ozq_cm_conv (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic [ozq_pkg::MM_W-1:0] mm,
	output logic      [ozq_pkg::CM_W-1:0] cm_s1
);
	import ozq_pkg::*;

	logic [2*MM_W-1:0] prod;

	assign prod = (2*MM_W)'(mm) * (2*MM_W)'(DIV10_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			cm_s1 <= prod[DIV10_SHIFT +: CM_W];
		end
	end

endmodule

`default_nettype wire

/* sv/ozq_lane.sv */
// ----------------------------------------------------------------------------
// ozq_lane: per-zone band qualifier
// Classifies one zone distance into the stop and slow bands and keeps the
// saturating run counters and pending flags of that zone.
// ----------------------------------------------------------------------------
`default_nettype none

module ozq_lane (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic [ozq_pkg::CM_W-1:0] dist_cm,
	input  wire ozq_pkg::zone_cfg_t       cfg,
	output ozq_pkg::lane_flags_t          flags
);
	import ozq_pkg::*;

	logic [RUN_W-1:0] stop_cnt_q, slow_cnt_q;
	logic             stop_pend_q, slow_pend_q;
	logic [RUN_W-1:0] stop_inc, slow_inc;
	logic [RUN_W-1:0] stop_cnt_d, slow_cnt_d;
	logic             stop_pend_d, slow_pend_d;
	logic             nonzero, stop_hit, slow_hit;

	always_comb begin
		nonzero  = (dist_cm != '0);
		stop_hit = nonzero && (dist_cm <= cfg.stop_thr);
		slow_hit = nonzero && (dist_cm > cfg.stop_thr) && (dist_cm <= cfg.slow_thr);

		stop_inc = (stop_cnt_q == RUN_MAX) ? stop_cnt_q : stop_cnt_q + 1'b1;
		slow_inc = (slow_cnt_q == RUN_MAX) ? slow_cnt_q : slow_cnt_q + 1'b1;

		stop_cnt_d  = stop_hit ? stop_inc : '0;
		slow_cnt_d  = slow_hit ? slow_inc : '0;
		stop_pend_d = stop_hit && (stop_pend_q || (stop_inc >= cfg.qualify));
		slow_pend_d = slow_hit && (slow_pend_q || (slow_inc >= cfg.qualify));

		flags.stop = stop_pend_d;
		flags.slow = slow_pend_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_cnt_q  <= '0;
			slow_cnt_q  <= '0;
			stop_pend_q <= 1'b0;
			slow_pend_q <= 1'b0;
		end else if (en) begin
			stop_cnt_q  <= stop_cnt_d;
			slow_cnt_q  <= slow_cnt_d;
			stop_pend_q <= stop_pend_d;
			slow_pend_q <= slow_pend_d;
		end
	end

endmodule

`default_nettype wire

/* sv/obstacle_zone_qualifier.sv */
// ----------------------------------------------------------------------------
// obstacle_zone_qualifier: debounced threshold zone detector
// Converts three range readings to centimetre zones, qualifies each zone in
// its own lane and merges the lane flags into stop and slow indications.
// ----------------------------------------------------------------------------
// Usage:
// Readings enter on the in_valid/in_ready channel, one transaction per
// reading; one result leaves on the out_valid/out_ready channel for each.
// Each accepted reading is converted to centimetres in three reciprocal
// multipliers and registered in the conversion stage; from there the
// front-zone minimum is taken, the three zone lanes run and the output
// register is loaded. Throughput is one transaction per cycle while the
// receiver accepts; the output register is the only limit, and a new
// reading is taken while a finished result waits as long as the conversion
// stage has room. When the receiver stalls, the result holds in the output
// register and one more reading waits in the conversion stage; after that
// in_ready drops. Reset clears the run counters, pending flags and stage
// valid bits and loads the registers with their default thresholds.
// Registers are written through cfg_we, cfg_index and cfg_wdata; the user
// must write them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module obstacle_zone_qualifier (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire ozq_pkg::in_item_t        in_data,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output ozq_pkg::out_item_t            out_data,
	input  wire logic                     cfg_we,
	input  wire ozq_pkg::cfg_index_t      cfg_index,
	input  wire logic [ozq_pkg::CM_W-1:0] cfg_wdata
);
	import ozq_pkg::*;

	logic [CM_W-1:0]   stop_thr_q, slow_thr_q, safe_dist_q;
	logic [QUAL_W-1:0] qualify_q;
	zone_cfg_t         zone_cfg;

	logic              valid_s1, rv_s1;
	logic [CM_W-1:0]   center_s1, left_s1, right_s1;
	logic              load_s1, adv;

	logic [CM_W-1:0]   front_cm;
	logic [CM_W:0]     safe_inc;
	logic [CM_W-1:0]   safe_out;
	logic              lane_en;
	lane_flags_t       flags_front, flags_left, flags_right;
	out_item_t         result;

	logic              out_valid_q;
	out_item_t         out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_thr_q  <= STOP_THR_RST;
			slow_thr_q  <= SLOW_THR_RST;
			safe_dist_q <= SAFE_DIST_RST;
			qualify_q   <= QUALIFY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STOP_THR:  stop_thr_q  <= cfg_wdata;
				REG_SLOW_THR:  slow_thr_q  <= cfg_wdata;
				REG_SAFE_DIST: safe_dist_q <= cfg_wdata;
				REG_QUALIFY:   qualify_q   <= cfg_wdata[QUAL_W-1:0];
			endcase
		end
	end

	assign zone_cfg = '{stop_thr: stop_thr_q, slow_thr: slow_thr_q, qualify: qualify_q};

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || !out_valid_q || out_ready;
	assign load_s1  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			rv_s1 <= in_data.reading_valid;
		end
	end

	ozq_cm_conv u_conv_center (.clk(clk), .en(load_s1), .mm(in_data.center_mm), .cm_s1(center_s1));
	ozq_cm_conv u_conv_left   (.clk(clk), .en(load_s1), .mm(in_data.left_mm),   .cm_s1(left_s1));
	ozq_cm_conv u_conv_right  (.clk(clk), .en(load_s1), .mm(in_data.right_mm),  .cm_s1(right_s1));

	always_comb begin
		front_cm = center_s1;
		if (left_s1 < front_cm) begin
			front_cm = left_s1;
		end
		if (right_s1 < front_cm) begin
			front_cm = right_s1;
		end
	end

	assign lane_en = adv && rv_s1;

	ozq_lane u_lane_front (
		.clk(clk), .arst_n(arst_n), .en(lane_en), .dist_cm(front_cm),
		.cfg(zone_cfg), .flags(flags_front)
	);
	ozq_lane u_lane_left (
		.clk(clk), .arst_n(arst_n), .en(lane_en), .dist_cm(left_s1),
		.cfg(zone_cfg), .flags(flags_left)
	);
	ozq_lane u_lane_right (
		.clk(clk), .arst_n(arst_n), .en(lane_en), .dist_cm(right_s1),
		.cfg(zone_cfg), .flags(flags_right)
	);

	always_comb begin
		safe_inc = {1'b0, safe_dist_q} + (CM_W+1)'(1);
		safe_out = safe_inc[CM_W] ? CM_MAX : safe_inc[CM_W-1:0];
		if (rv_s1) begin
			result.stop_alert = flags_front.stop | flags_left.stop | flags_right.stop;
			result.slow_alert = flags_front.slow | flags_left.slow | flags_right.slow;
			result.front_cm   = front_cm;
			result.left_cm    = left_s1;
			result.right_cm   = right_s1;
		end else begin
			result.stop_alert = 1'b0;
			result.slow_alert = 1'b0;
			result.front_cm   = safe_out;
			result.left_cm    = safe_out;
			result.right_cm   = safe_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// An invalid reading always yields a result with both flags clear.
	a_invalid_clears_flags: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !rv_s1 |=> !out_data.stop_alert && !out_data.slow_alert)
		else $error("invalid reading produced a set flag");

	// The input side only stalls when the conversion stage is full behind a stalled output.
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a full pipeline");

	// The stop and slow bands exclude each other, so no lane holds both flags.
	a_lane_bands_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		lane_en |-> !(flags_front.stop && flags_front.slow) &&
			!(flags_left.stop && flags_left.slow) &&
			!(flags_right.stop && flags_right.slow))
		else $error("zone lane flagged both stop and slow");

	// A transaction in the conversion stage is never lost while the output drains.
	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |=> out_valid_q)
		else $error("conversion stage did not advance into a free output register");

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the obstacle zone qualifier
// Readings are sent on the input channel and the zone reports are compared
// field by field against a predictor held in the bench. A short directed
// table opens the run; random bursts of band-targeted readings follow under
// several register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;

	import ozq_pkg::*;

	localparam logic [MM_W-1:0] MM_PER_CM   = 16'd10;
	localparam int unsigned     CM_TOP      = 6553;
	localparam int              DRILL_ROWS  = 19;
	localparam int              PHASES      = 10;
	localparam int              PHASE_ITEMS = 160;
	localparam int              STALL_LIMIT = 2000;

	typedef enum logic [1:0] {
		BAND_STOP,
		BAND_SLOW,
		BAND_FAR,
		BAND_ZERO
	} band_t;

	typedef struct packed {
		logic      typed;
		in_item_t  rd;
		out_item_t res;
	} drill_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_data;
	logic       cfg_we;
	cfg_index_t cfg_index;
	logic [CM_W-1:0] cfg_wdata;

	logic [CM_W-1:0]   stop_thr_cm;
	logic [CM_W-1:0]   slow_thr_cm;
	logic [CM_W-1:0]   safe_cm;
	logic [QUAL_W-1:0] qual_len;
	logic [RUN_W-1:0]  stop_run [ZONES];
	logic [RUN_W-1:0]  slow_run [ZONES];
	logic              stop_flag [ZONES];
	logic              slow_flag [ZONES];

	out_item_t   zone_reports [$];
	int unsigned mismatches = 0;
	drill_row_t  drill [DRILL_ROWS];

	always #6 clk = ~clk;

	obstacle_zone_qualifier i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	task automatic advance_run(input logic hit, inout logic [RUN_W-1:0] run, inout logic flag);
		if (hit) begin
			if (run != RUN_MAX)
				run = run + 1'b1;
			if (run >= qual_len)
				flag = 1'b1;
		end else begin
			run  = '0;
			flag = 1'b0;
		end
	endtask

	task automatic predict_zones(input in_item_t rd, output out_item_t res);
		logic [MM_W-1:0] zone_cm [ZONES];
		logic [MM_W-1:0] nearest;
		logic [MM_W-1:0] stop_lim;
		logic [MM_W-1:0] slow_lim;
		logic [CM_W-1:0] safe_out;
		logic            stop_any;
		logic            slow_any;
		res = '0;
		if (!rd.reading_valid) begin
			safe_out     = (safe_cm == CM_MAX) ? CM_MAX : safe_cm + 1'b1;
			res.front_cm = safe_out;
			res.left_cm  = safe_out;
			res.right_cm = safe_out;
		end else begin
			nearest = rd.center_mm;
			if (rd.left_mm < nearest)
				nearest = rd.left_mm;
			if (rd.right_mm < nearest)
				nearest = rd.right_mm;
			zone_cm[0] = nearest / MM_PER_CM;
			zone_cm[1] = rd.left_mm / MM_PER_CM;
			zone_cm[2] = rd.right_mm / MM_PER_CM;
			stop_lim   = {3'b000, stop_thr_cm};
			slow_lim   = {3'b000, slow_thr_cm};
			stop_any   = 1'b0;
			slow_any   = 1'b0;
			for (int z = 0; z < ZONES; z++) begin
				advance_run(zone_cm[z] != '0 && zone_cm[z] <= stop_lim,
					stop_run[z], stop_flag[z]);
				advance_run(zone_cm[z] != '0 && zone_cm[z] > stop_lim && zone_cm[z] <= slow_lim,
					slow_run[z], slow_flag[z]);
				stop_any = stop_any | stop_flag[z];
				slow_any = slow_any | slow_flag[z];
			end
			res.stop_alert = stop_any;
			res.slow_alert = slow_any;
			res.front_cm   = zone_cm[0][CM_W-1:0];
			res.left_cm    = zone_cm[1][CM_W-1:0];
			res.right_cm   = zone_cm[2][CM_W-1:0];
		end
	endtask

	// Picks a distance in millimetres whose centimetre value falls in the band
	// under the current thresholds; an empty band gives a random distance.
	function automatic logic [MM_W-1:0] band_reading(input band_t band);
		int unsigned lo;
		int unsigned hi;
		int unsigned cm;
		int unsigned mm;
		lo = 0;
		hi = 0;
		case (band)
			BAND_STOP: begin
				lo = 1;
				hi = 32'(stop_thr_cm);
			end
			BAND_SLOW: begin
				lo = stop_thr_cm + 1;
				hi = 32'(slow_thr_cm);
			end
			BAND_FAR: begin
				lo = ((stop_thr_cm > slow_thr_cm) ? stop_thr_cm : slow_thr_cm) + 1;
				hi = CM_TOP;
			end
			default: begin
				lo = 0;
				hi = 0;
			end
		endcase
		if (hi > CM_TOP)
			hi = CM_TOP;
		if (lo > hi)
			return MM_W'($urandom_range(0, 65535));
		case ($urandom_range(0, 7))
			0:       cm = lo;
			1:       cm = hi;
			default: cm = $urandom_range(hi, lo);
		endcase
		mm = cm * 10 + $urandom_range(0, 9);
		if (mm > 65535)
			mm = 65535;
		return mm[MM_W-1:0];
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic write_register(input cfg_index_t idx, input logic [CM_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_STOP_THR:  stop_thr_cm = value;
			REG_SLOW_THR:  slow_thr_cm = value;
			REG_SAFE_DIST: safe_cm     = value;
			REG_QUALIFY:   qual_len    = value[QUAL_W-1:0];
			default:       ;
		endcase
		@(negedge clk);
	endtask

	task automatic send_reading(input in_item_t rd, input int unsigned gap, input logic typed,
			input out_item_t typed_res);
		out_item_t res;
		in_valid <= 1'b1;
		in_data  <= rd;
		do
			@(posedge clk);
		while (!in_ready);
		predict_zones(rd, res);
		zone_reports.push_back(typed ? typed_res : res);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic settle();
		while (zone_reports.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : report_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (zone_reports.size() == 0) begin
				$display("%0t: zone report with none outstanding: expected none, got %p",
					$time, out_data);
				mismatches++;
			end else begin
				want = zone_reports.pop_front();
				check_field("stop_alert", 32'(want.stop_alert), 32'(out_data.stop_alert));
				check_field("slow_alert", 32'(want.slow_alert), 32'(out_data.slow_alert));
				check_field("front_cm", 32'(want.front_cm), 32'(out_data.front_cm));
				check_field("left_cm", 32'(want.left_cm), 32'(out_data.left_cm));
				check_field("right_cm", 32'(want.right_cm), 32'(out_data.right_cm));
			end
		end
	end

	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	// The receiver first holds off long enough for the block to fill and
	// stall its input, then alternates random stretches of accepting and
	// stalling.
	initial begin : receiver
		int unsigned span;
		int unsigned r;
		out_ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		repeat (40) @(negedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				out_ready <= 1'b1;
				span = $urandom_range(1, 8);
			end else if (r < 90) begin
				out_ready <= 1'b0;
				span = $urandom_range(1, 3);
			end else if (r < 97) begin
				out_ready <= 1'b1;
				span = $urandom_range(20, 60);
			end else begin
				out_ready <= 1'b0;
				span = $urandom_range(20, 80);
			end
			repeat (span) @(negedge clk);
		end
	end

	initial begin : stimulus
		band_t           bands [ZONES];
		in_item_t        rd;
		logic [CM_W-1:0] stop_val;
		logic [CM_W-1:0] slow_val;
		logic [CM_W-1:0] safe_val;
		logic [CM_W-1:0] qual_val;
		int unsigned     sent;
		int unsigned     burst_len;
		logic            no_gaps;

		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_STOP_THR;
		cfg_wdata = '0;

		stop_thr_cm = STOP_THR_RST;
		slow_thr_cm = SLOW_THR_RST;
		safe_cm     = SAFE_DIST_RST;
		qual_len    = QUALIFY_RST;
		for (int z = 0; z < ZONES; z++) begin
			stop_run[z]  = '0;
			slow_run[z]  = '0;
			stop_flag[z] = 1'b0;
			slow_flag[z] = 1'b0;
		end

		// typed, {valid, centre, left, right}, {stop, slow, front, left, right}
		drill[0]  = {1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 13'd51, 13'd51, 13'd51};
		drill[1]  = {1'b1, 1'b1, 16'd65535, 16'd65535, 16'd65535,
			1'b0, 1'b0, 13'd6553, 13'd6553, 13'd6553};
		drill[2]  = {1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0};
		drill[3]  = {1'b1, 1'b1, 16'd50, 16'd65535, 16'd65535,
			1'b0, 1'b0, 13'd5, 13'd6553, 13'd6553};
		drill[4]  = {1'b1, 1'b1, 16'd50, 16'd65535, 16'd65535,
			1'b1, 1'b0, 13'd5, 13'd6553, 13'd6553};
		drill[5]  = {1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			1'b0, 1'b0, 13'd51, 13'd51, 13'd51};
		drill[6]  = {1'b1, 1'b1, 16'd50, 16'd65535, 16'd65535,
			1'b1, 1'b0, 13'd5, 13'd6553, 13'd6553};
		drill[7]  = {1'b0, 1'b1, 16'd109, 16'd209, 16'd309, 41'd0};
		drill[8]  = {1'b0, 1'b1, 16'd110, 16'd209, 16'd310, 41'd0};
		drill[9]  = {1'b1, 1'b1, 16'd9, 16'd9, 16'd9, 1'b0, 1'b0, 13'd0, 13'd0, 13'd0};
		drill[10] = {1'b0, 1'b1, 16'd65535, 16'd100, 16'd65535, 41'd0};
		drill[11] = {1'b0, 1'b1, 16'd65535, 16'd100, 16'd65535, 41'd0};
		drill[12] = {1'b0, 1'b1, 16'd0, 16'd100, 16'd100, 41'd0};
		drill[13] = {1'b0, 1'b1, 16'd300, 16'd300, 16'd300, 41'd0};
		drill[14] = {1'b0, 1'b1, 16'd300, 16'd300, 16'd300, 41'd0};
		drill[15] = {1'b1, 1'b0, 16'h5555, 16'hAAAA, 16'h5555,
			1'b0, 1'b0, 13'd51, 13'd51, 13'd51};
		drill[16] = {1'b0, 1'b1, 16'd300, 16'd300, 16'd300, 41'd0};
		drill[17] = {1'b1, 1'b1, 16'd319, 16'd319, 16'd319,
			1'b0, 1'b0, 13'd31, 13'd31, 13'd31};
		drill[18] = {1'b0, 1'b1, 16'h8000, 16'h7FFF, 16'hAAAA, 41'd0};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DRILL_ROWS; i++)
			send_reading(drill[i].rd, 0, drill[i].typed, drill[i].res);
		in_valid <= 1'b0;

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: begin
					stop_val = '0;
					slow_val = '0;
					safe_val = '0;
					qual_val = '0;
				end
				1: begin
					stop_val = CM_MAX;
					slow_val = CM_MAX;
					safe_val = CM_MAX;
					qual_val = 13'd15;
				end
				2: begin
					stop_val = 13'd20;
					slow_val = 13'd10;
					safe_val = CM_MAX - 1'b1;
					qual_val = 13'd1;
				end
				3: begin
					stop_val = 13'd1;
					slow_val = 13'd2;
					safe_val = 13'd6552;
					qual_val = 13'd3;
				end
				default: begin
					stop_val = CM_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
						: $urandom_range(0, 200));
					if ($urandom_range(0, 3) == 0)
						slow_val = CM_W'($urandom_range(0, stop_val));
					else if (stop_val > 7800)
						slow_val = CM_MAX;
					else
						slow_val = CM_W'(stop_val + $urandom_range(1, 300));
					safe_val = CM_W'($urandom_range(0, 8191));
					qual_val = CM_W'(($urandom_range(0, 511) << 4) | $urandom_range(0, 15));
				end
			endcase
			write_register(REG_STOP_THR, stop_val);
			write_register(REG_SLOW_THR, slow_val);
			write_register(REG_SAFE_DIST, safe_val);
			write_register(REG_QUALIFY, qual_val);
			cfg_we <= 1'b0;

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst_len = $urandom_range(1, 20);
				no_gaps   = ($urandom_range(0, 3) == 0);
				for (int z = 0; z < ZONES; z++)
					bands[z] = band_t'($urandom_range(0, 3));
				for (int k = 0; k < burst_len; k++) begin
					if ($urandom_range(0, 19) == 0) begin
						rd.reading_valid = 1'($urandom_range(0, 1));
						rd.center_mm     = MM_W'($urandom_range(0, 65535));
						rd.left_mm       = MM_W'($urandom_range(0, 65535));
						rd.right_mm      = MM_W'($urandom_range(0, 65535));
					end else if ($urandom_range(0, 29) == 0) begin
						rd.reading_valid = 1'b0;
						rd.center_mm     = band_reading(bands[0]);
						rd.left_mm       = band_reading(bands[1]);
						rd.right_mm      = band_reading(bands[2]);
					end else begin
						rd.reading_valid = 1'b1;
						rd.center_mm     = band_reading(bands[0]);
						rd.left_mm       = band_reading(bands[1]);
						rd.right_mm      = band_reading(bands[2]);
					end
					send_reading(rd, no_gaps ? 0 : pick_gap(), 1'b0, '0);
					sent++;
				end
			end
			in_valid <= 1'b0;
		end

		settle();
		repeat (4) @(negedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
